[src/bsg_pkg.sv]
// Shared types, constants and codes of the safe grant unit.
package bsg_pkg;

  localparam int PROCESSES  = 8;
  localparam int RESOURCES  = 4;
  localparam int AMOUNT_W   = 16;
  localparam int PROC_W     = 3;
  localparam int PIN_W      = 4;
  localparam int RIN_W      = 3;
  localparam int WORK_W     = AMOUNT_W + $clog2(PROCESSES + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [1:0] {
    ACT_LOAD_AVAIL = 2'd0,
    ACT_LOAD_MAX   = 2'd1,
    ACT_LOAD_ALLOC = 2'd2,
    ACT_REQUEST    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_CLAIM    = 3'd1,
    ST_AVAIL    = 3'd2,
    ST_UNSAFE   = 3'd3,
    ST_LOADED   = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCS = 2'd0,
    REG_RES   = 2'd1
  } reg_idx_e;

  typedef struct packed {
    action_e             action;
    logic [PROC_W-1:0]   process;
    logic [AMOUNT_W-1:0] amount0;
    logic [AMOUNT_W-1:0] amount1;
    logic [AMOUNT_W-1:0] amount2;
    logic [AMOUNT_W-1:0] amount3;
  } in_t;

  typedef struct packed {
    logic    granted;
    status_e status;
  } out_t;

  typedef struct packed {
    logic claim_fail;
    logic avail_fail;
    logic fits;
  } lane_res_t;

endpackage

[src/bsg_lane.sv]
// One resource lane: claim, availability and safety compares for one resource type.
module bsg_lane (
  input  logic [bsg_pkg::AMOUNT_W-1:0] max_i,
  input  logic [bsg_pkg::AMOUNT_W-1:0] alloc_i,
  input  logic [bsg_pkg::AMOUNT_W-1:0] req_i,
  input  logic [bsg_pkg::AMOUNT_W-1:0] avail_i,
  input  logic [bsg_pkg::WORK_W-1:0]   work_i,
  input  logic                         add_req_i,
  output bsg_pkg::lane_res_t           res_o,
  output logic [bsg_pkg::AMOUNT_W:0]   claim_o,
  output logic [bsg_pkg::WORK_W-1:0]   work_sum_o
);
  import bsg_pkg::*;

  logic [AMOUNT_W:0] claim;
  logic [AMOUNT_W:0] alloc_eff;
  logic [WORK_W:0]   total;

  assign claim     = {1'b0, alloc_i} + {1'b0, req_i};
  assign alloc_eff = add_req_i ? claim : {1'b0, alloc_i};
  assign total     = {1'b0, work_i} + {{(WORK_W - AMOUNT_W){1'b0}}, alloc_eff};

  assign res_o.claim_fail = claim > {1'b0, max_i};
  assign res_o.avail_fail = req_i > avail_i;
  assign res_o.fits       = {{(WORK_W + 1 - AMOUNT_W){1'b0}}, max_i} <= total;
  assign claim_o          = claim;
  assign work_sum_o       = total[WORK_W-1:0];

endmodule

[src/bsg_merge.sv]
// Merge of lane flags: first failing resource and all-lanes-fit.
module bsg_merge (
  input  bsg_pkg::lane_res_t            res_i [bsg_pkg::RESOURCES],
  input  logic [bsg_pkg::RESOURCES-1:0] en_i,
  output bsg_pkg::status_e              fail_o,
  output logic                          fit_o
);
  import bsg_pkg::*;

  always_comb begin
    fail_o = ST_GRANTED;
    fit_o  = 1'b1;
    for (int r = RESOURCES - 1; r >= 0; r--) begin
      if (en_i[r]) begin
        if (!res_i[r].fits) fit_o = 1'b0;
        if (res_i[r].claim_fail) begin
          fail_o = ST_CLAIM;
        end else if (res_i[r].avail_fail) begin
          fail_o = ST_AVAIL;
        end
      end
    end
  end

endmodule

[src/bankers_safe_grant.sv]
// Top level of the banker's-algorithm safe grant unit.
// Usage:
//   Drive in_i and raise start while busy is low; the beat is taken at that edge.
//   Load beats (available vector, max need row, allocation row) write the tables
//   at once and answer with status loaded on done_o in the next cycle.
//   A request beat first checks claim and availability over all resource lanes
//   in use at once, then runs the safety scan: one process row per cycle, every
//   resource compared in its own lane, passes repeated while a pass finishes some
//   process. A request rejected by the check answers right after it; otherwise
//   it answers when the scan ends. busy is high while a request is at work.
//   res_o is valid for exactly one cycle with done_o; the receiver cannot stall.
//   A grant commits the new allocation and available vector with the answer.
//   Registers are written over cfg_valid_i/cfg_ready_o (always ready); the user
//   must write them only while idle, which the block itself does not enforce.
//   Reset clears all tables and sets 8 processes and 4 resources in use.
module bankers_safe_grant (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  bsg_pkg::in_t                    in_i,
  output logic                            done_o,
  output bsg_pkg::out_t                   res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bsg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bsg_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bsg_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_q, state_d;

  logic [PIN_W-1:0] pin_q;
  logic [RIN_W-1:0] rin_q;
  logic [PIN_W-1:0] np;
  logic [RIN_W-1:0] nr;

  logic [AMOUNT_W-1:0] avail_q [RESOURCES];
  logic [AMOUNT_W-1:0] max_q   [PROCESSES][RESOURCES];
  logic [AMOUNT_W-1:0] alloc_q [PROCESSES][RESOURCES];

  logic [AMOUNT_W-1:0] req_q     [RESOURCES];
  logic [AMOUNT_W-1:0] left_q    [RESOURCES];
  logic [AMOUNT_W-1:0] new_alloc_q [RESOURCES];
  logic [WORK_W-1:0]   work_q    [RESOURCES];
  logic [PROC_W-1:0]   proc_q;

  logic [PROCESSES-1:0] fin_q;
  logic [PROC_W-1:0]    idx_q;
  logic [PIN_W-1:0]     cnt_q;
  logic                 prog_q;

  logic done_q;
  out_t res_q;

  logic [AMOUNT_W-1:0] in_amt [RESOURCES];
  logic [PROC_W-1:0]   rd_idx;
  logic [RESOURCES-1:0] lane_en;
  lane_res_t           lane_res [RESOURCES];
  logic [AMOUNT_W:0]   lane_claim [RESOURCES];
  logic [WORK_W-1:0]   lane_work  [RESOURCES];
  status_e             fail;
  logic                all_fit;

  logic              accept;
  logic              cand;
  logic [PIN_W-1:0]  cnt_n;
  logic              prog_n;
  logic              last;
  logic              grant;
  logic              unsafe;

  assign accept      = start && !busy;
  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign res_o       = res_q;

  assign np = (pin_q > PIN_W'(PROCESSES)) ? PIN_W'(PROCESSES) : pin_q;
  assign nr = (rin_q > RIN_W'(RESOURCES)) ? RIN_W'(RESOURCES) : rin_q;

  assign in_amt[0] = in_i.amount0;
  assign in_amt[1] = in_i.amount1;
  assign in_amt[2] = in_i.amount2;
  assign in_amt[3] = in_i.amount3;

  assign rd_idx = (state_q == S_SCAN) ? idx_q : proc_q;

  for (genvar r = 0; r < RESOURCES; r++) begin : g_lane
    assign lane_en[r] = RIN_W'(r) < nr;
    bsg_lane u_lane (
      .max_i      (max_q[rd_idx][r]),
      .alloc_i    (alloc_q[rd_idx][r]),
      .req_i      (req_q[r]),
      .avail_i    (avail_q[r]),
      .work_i     (work_q[r]),
      .add_req_i  ((state_q == S_CHK) || (idx_q == proc_q)),
      .res_o      (lane_res[r]),
      .claim_o    (lane_claim[r]),
      .work_sum_o (lane_work[r])
    );
  end

  bsg_merge u_merge (
    .res_i  (lane_res),
    .en_i   (lane_en),
    .fail_o (fail),
    .fit_o  (all_fit)
  );

  assign cand   = !fin_q[idx_q] && all_fit;
  assign cnt_n  = cnt_q + PIN_W'(cand);
  assign prog_n = prog_q || cand;
  assign last   = {1'b0, idx_q} == (np - PIN_W'(1));
  assign grant  = (state_q == S_SCAN) && last && (cnt_n == np);
  assign unsafe = (state_q == S_SCAN) && last && (cnt_n != np) && !prog_n;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_i.action == ACT_REQUEST) state_d = S_CHK;
      end
      S_CHK: begin
        if ({1'b0, proc_q} >= np || fail != ST_GRANTED) state_d = S_IDLE;
        else state_d = S_SCAN;
      end
      S_SCAN: begin
        if (grant || unsafe) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pin_q   <= PIN_W'(PROCESSES);
      rin_q   <= RIN_W'(RESOURCES);
      done_q  <= 1'b0;
      res_q   <= '{granted: 1'b0, status: ST_GRANTED};
      fin_q   <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      prog_q  <= 1'b0;
      for (int r = 0; r < RESOURCES; r++) begin
        avail_q[r] <= '0;
      end
      for (int p = 0; p < PROCESSES; p++) begin
        for (int r = 0; r < RESOURCES; r++) begin
          max_q[p][r]   <= '0;
          alloc_q[p][r] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_PROCS) pin_q <= cfg_data_i[PIN_W-1:0];
        else if (cfg_index_i == REG_RES) rin_q <= cfg_data_i[RIN_W-1:0];
      end
      if (accept && in_i.action != ACT_REQUEST) begin
        done_q <= 1'b1;
        res_q  <= '{granted: 1'b0, status: ST_LOADED};
        for (int r = 0; r < RESOURCES; r++) begin
          unique case (in_i.action)
            ACT_LOAD_AVAIL: avail_q[r] <= in_amt[r];
            ACT_LOAD_MAX:   max_q[in_i.process][r] <= in_amt[r];
            ACT_LOAD_ALLOC: alloc_q[in_i.process][r] <= in_amt[r];
            default: ;
          endcase
        end
      end
      if (state_q == S_CHK) begin
        fin_q  <= '0;
        idx_q  <= '0;
        cnt_q  <= '0;
        prog_q <= 1'b0;
        if ({1'b0, proc_q} >= np) begin
          done_q <= 1'b1;
          res_q  <= '{granted: 1'b0, status: ST_CLAIM};
        end else if (fail != ST_GRANTED) begin
          done_q <= 1'b1;
          res_q  <= '{granted: 1'b0, status: fail};
        end
      end
      if (state_q == S_SCAN) begin
        if (cand) fin_q[idx_q] <= 1'b1;
        if (last) begin
          idx_q  <= '0;
          cnt_q  <= cnt_n;
          prog_q <= 1'b0;
        end else begin
          idx_q  <= idx_q + PROC_W'(1);
          cnt_q  <= cnt_n;
          prog_q <= prog_n;
        end
        if (grant) begin
          done_q <= 1'b1;
          res_q  <= '{granted: 1'b1, status: ST_GRANTED};
          for (int r = 0; r < RESOURCES; r++) begin
            if (lane_en[r]) begin
              avail_q[r]          <= left_q[r];
              alloc_q[proc_q][r]  <= new_alloc_q[r];
            end
          end
        end else if (unsafe) begin
          done_q <= 1'b1;
          res_q  <= '{granted: 1'b0, status: ST_UNSAFE};
        end
      end
    end
  end

  // request payload and work vector
  always_ff @(posedge clk_i) begin
    if (accept && in_i.action == ACT_REQUEST) begin
      proc_q <= in_i.process;
      for (int r = 0; r < RESOURCES; r++) begin
        req_q[r] <= in_amt[r];
      end
    end
    if (state_q == S_CHK) begin
      for (int r = 0; r < RESOURCES; r++) begin
        left_q[r]      <= avail_q[r] - req_q[r];
        new_alloc_q[r] <= lane_claim[r][AMOUNT_W-1:0];
        work_q[r]      <= lane_en[r] ? WORK_W'(avail_q[r] - req_q[r]) : '0;
      end
    end
    if (state_q == S_SCAN && cand) begin
      for (int r = 0; r < RESOURCES; r++) begin
        if (lane_en[r]) work_q[r] <= lane_work[r];
      end
    end
  end

`ifndef SYNTHESIS
  a_load_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.action != ACT_REQUEST |=> done_o && res_o.status == ST_LOADED)
    else $error("load beat not acknowledged");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");
  a_grant_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.granted |-> $past(state_q) == S_SCAN)
    else $error("grant without safety scan");
  a_scan_np: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> np != '0 && {1'b0, proc_q} < np)
    else $error("scan with no process in use");
`endif

endmodule

[test/bankers_safe_grant_tb.sv]
// Testbench for the safe grant unit: mirrored table model, directed and random beats.
`timescale 1ns / 1ps

module bankers_safe_grant_tb;
  import bsg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST  = 2'd3;

  class grant_scoreboard;
    int unsigned procs_in_use;
    int unsigned res_in_use;
    int unsigned avail_vec[RESOURCES];
    int unsigned max_tab[PROCESSES][RESOURCES];
    int unsigned alloc_tab[PROCESSES][RESOURCES];
    out_t        answers_due[$];
    int          errors;

    function void clear_tables();
      procs_in_use = 8;
      res_in_use   = 4;
      errors       = 0;
      foreach (avail_vec[r]) avail_vec[r] = 0;
      foreach (max_tab[p, r]) begin
        max_tab[p][r]   = 0;
        alloc_tab[p][r] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_PROCS) procs_in_use = data;
      else if (idx == REG_RES) res_in_use = data & 4'h7;
    endfunction

    function void note_beat(in_t beat);
      int unsigned amt[RESOURCES];
      int unsigned work[RESOURCES];
      int unsigned alloc2[PROCESSES][RESOURCES];
      bit          done_p[PROCESSES];
      int unsigned np, nr, p, ndone;
      bit          progress, fits;
      out_t        ans;
      amt[0] = beat.amount0;
      amt[1] = beat.amount1;
      amt[2] = beat.amount2;
      amt[3] = beat.amount3;
      np = (procs_in_use > PROCESSES) ? PROCESSES : procs_in_use;
      nr = (res_in_use > RESOURCES) ? RESOURCES : res_in_use;
      p = beat.process;
      ans.granted = 1'b0;
      ans.status  = ST_LOADED;
      case (beat.action)
        ACT_LOAD_AVAIL: begin
          foreach (amt[r]) avail_vec[r] = amt[r];
        end
        ACT_LOAD_MAX: begin
          foreach (amt[r]) max_tab[p][r] = amt[r];
        end
        ACT_LOAD_ALLOC: begin
          foreach (amt[r]) alloc_tab[p][r] = amt[r];
        end
        default: begin
          ans.status = ST_GRANTED;
          if (p >= np) ans.status = ST_CLAIM;
          for (int r = 0; r < nr && ans.status == ST_GRANTED; r++) begin
            if (amt[r] + alloc_tab[p][r] > max_tab[p][r]) ans.status = ST_CLAIM;
            else if (amt[r] > avail_vec[r]) ans.status = ST_AVAIL;
          end
          if (ans.status == ST_GRANTED) begin
            alloc2 = alloc_tab;
            foreach (work[r]) work[r] = 0;
            for (int r = 0; r < nr; r++) begin
              work[r] = avail_vec[r] - amt[r];
              alloc2[p][r] += amt[r];
            end
            foreach (done_p[i]) done_p[i] = 0;
            ndone = 0;
            progress = 1;
            while (progress && ndone < np) begin
              progress = 0;
              for (int i = 0; i < np; i++) begin
                if (!done_p[i]) begin
                  fits = 1;
                  for (int r = 0; r < nr; r++)
                    if (max_tab[i][r] > work[r] + alloc2[i][r]) fits = 0;
                  if (fits) begin
                    for (int r = 0; r < nr; r++) work[r] += alloc2[i][r];
                    done_p[i] = 1;
                    ndone++;
                    progress = 1;
                  end
                end
              end
            end
            if (ndone != np) begin
              ans.status = ST_UNSAFE;
            end else begin
              for (int r = 0; r < nr; r++) begin
                avail_vec[r] -= amt[r];
                alloc_tab[p][r] = alloc2[p][r] & 16'hFFFF;
              end
              ans.granted = 1'b1;
            end
          end
        end
      endcase
      answers_due = {answers_due, ans};
    endfunction

    function void check_answer(out_t got);
      out_t want;
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected answer granted=%0d status=%0d",
                                   got.granted, got.status);
        return;
      end
      want = answers_due.pop_front();
      if (got.granted !== want.granted || got.status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("answer mismatch: expected granted=%0d status=%0d, got granted=%0d status=%0d",
                   want.granted, want.status, got.granted, got.status);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  in_t                   in_i;
  logic                  done_o;
  out_t                  res_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  grant_scoreboard sb;
  bit              idle_on;
  int              beats_sent;

  bankers_safe_grant u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_answer(res_o);
  end

  function automatic in_t make_beat(action_e act, int unsigned p, int unsigned a0,
                                    int unsigned a1, int unsigned a2, int unsigned a3);
    in_t b;
    b.action  = act;
    b.process = p[PROC_W-1:0];
    b.amount0 = a0[AMOUNT_W-1:0];
    b.amount1 = a1[AMOUNT_W-1:0];
    b.amount2 = a2[AMOUNT_W-1:0];
    b.amount3 = a3[AMOUNT_W-1:0];
    return b;
  endfunction

  function automatic int unsigned pick_amount(int unsigned span);
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, span);
  endfunction

  task automatic send_beat(in_t b);
    start <= 1'b1;
    in_i  <= b;
    do @(posedge clk_i); while (busy);
    sb.note_beat(b);
    beats_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic send(action_e act, int unsigned p, int unsigned a0, int unsigned a1,
                      int unsigned a2, int unsigned a3);
    send_beat(make_beat(act, p, a0, a1, a2, a3));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.answers_due.size() != 0 || busy) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n_req);
    int unsigned span, p, mx[RESOURCES];
    action_e     act;
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_PROCS, CFG_DATA_W'($urandom_range(0, 15)));
    if ($urandom_range(0, 2) == 0)
      write_reg(REG_RES, CFG_DATA_W'($urandom_range(0, 15)));
    if ($urandom_range(0, 9) == 0) write_reg($urandom_range(0, 1) ? REG_SPARE : REG_LAST,
                                             CFG_DATA_W'($urandom_range(0, 15)));
    span = $urandom_range(0, 1) ? 8 : 40;
    send(ACT_LOAD_AVAIL, $urandom_range(0, 7), pick_amount(span * 2),
         pick_amount(span * 2), pick_amount(span * 2), pick_amount(span * 2));
    for (int i = 0; i < PROCESSES; i++) begin
      foreach (mx[r]) mx[r] = pick_amount(span);
      send(ACT_LOAD_MAX, i, mx[0], mx[1], mx[2], mx[3]);
      if ($urandom_range(0, 7) == 0)
        send(ACT_LOAD_ALLOC, i, pick_amount(span), pick_amount(span),
             pick_amount(span), pick_amount(span));
      else
        send(ACT_LOAD_ALLOC, i, $urandom_range(0, mx[0]) / 2, $urandom_range(0, mx[1]) / 2,
             $urandom_range(0, mx[2]) / 2, $urandom_range(0, mx[3]) / 2);
    end
    for (int k = 0; k < n_req; k++) begin
      p = $urandom_range(0, 7);
      if ($urandom_range(0, 9) == 0) begin
        act = action_e'($urandom_range(0, 3));
        send(act, p, $urandom_range(0, 65535), $urandom_range(0, 65535),
             $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else begin
        send(ACT_REQUEST, p, pick_amount(span / 4), pick_amount(span / 4),
             pick_amount(span / 4), pick_amount(span / 4));
      end
    end
  endtask

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    sb = new();
    sb.clear_tables();
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    idle_on     = 1'b1;
    beats_sent  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every action, each corner of the checks
    send(ACT_REQUEST, 0, 0, 0, 0, 0);
    send(ACT_LOAD_AVAIL, 5, 65535, 65535, 65535, 65535);
    send(ACT_LOAD_MAX, 0, 65535, 65535, 65535, 65535);
    send(ACT_REQUEST, 0, 1, 1, 1, 1);
    send(ACT_REQUEST, 0, 65535, 0, 0, 0);
    send(ACT_LOAD_AVAIL, 0, 0, 0, 0, 0);
    send(ACT_REQUEST, 0, 0, 0, 0, 1);
    send(ACT_LOAD_AVAIL, 0, 2, 2, 2, 2);
    send(ACT_LOAD_MAX, 1, 10, 10, 10, 10);
    send(ACT_LOAD_ALLOC, 0, 0, 0, 0, 0);
    send(ACT_REQUEST, 0, 2, 2, 2, 2);
    send(ACT_LOAD_ALLOC, 1, 20, 20, 20, 20);
    send(ACT_REQUEST, 0, 2, 2, 2, 2);
    send(ACT_LOAD_MAX, 7, 65535, 21845, 43690, 0);
    send(ACT_LOAD_ALLOC, 7, 0, 43690, 21845, 65535);
    send(ACT_REQUEST, 7, 1, 0, 0, 0);
    write_reg(REG_PROCS, 3);
    write_reg(REG_RES, 1);
    send(ACT_REQUEST, 5, 0, 0, 0, 0);
    send(ACT_REQUEST, 2, 0, 9, 9, 9);
    write_reg(REG_PROCS, 0);
    write_reg(REG_RES, 0);
    send(ACT_REQUEST, 0, 0, 0, 0, 0);
    write_reg(REG_PROCS, 15);
    write_reg(REG_RES, 7);
    write_reg(REG_SPARE, 15);
    send(ACT_REQUEST, 6, 0, 0, 0, 0);
    write_reg(REG_PROCS, 8);
    write_reg(REG_RES, 4);

    while (beats_sent < 1750) begin
      if (beats_sent > 1450) idle_on = 1'b0;
      random_phase($urandom_range(10, 50));
    end

    drain();
    repeat (80) @(posedge clk_i);
    if (sb.errors == 0 && sb.answers_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[bankers_safe_grant.f]
src/bsg_pkg.sv
src/bsg_lane.sv
src/bsg_merge.sv
src/bankers_safe_grant.sv
test/bankers_safe_grant_tb.sv
